/* src/bbsps_pkg.sv */
// ----------------------------------------------------------------------------
// bbsps_pkg: shared types and constants for the box screen size core
// Field layouts, fixed-point widths and divider helpers.
// ----------------------------------------------------------------------------
package bbsps_pkg;

  localparam int COORD_W   = 16;
  localparam int ENTRY_W   = 16;
  localparam int ROW_W     = 4 * ENTRY_W;
  localparam int SCREEN_W  = 14;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 14'd1920;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 14'd1080;

  // transform: Q8.8 times Q4.12, four terms summed
  localparam int PROD_W   = COORD_W + ENTRY_W;
  localparam int P_W      = PROD_W + 2;
  localparam int MAG_W    = P_W - 1;
  localparam int ONE_SHIFT = 8;

  // ndc divide, 16 fraction bits
  localparam int NDC_FRAC   = 16;
  localparam int NUM_W      = MAG_W + NDC_FRAC;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIVN_W     = DIV_STAGES * DIV_BITS;
  localparam int REM_W      = MAG_W + 1;
  // |w| >= 105 bounds the quotient below 2^43
  localparam int Q_W        = 43;
  localparam int NDC_W      = Q_W + 1;
  localparam int SPAN_W     = NDC_W + 1;
  localparam int SCALED_W   = SPAN_W + SCREEN_W;
  localparam int SIZE_SHIFT = NDC_FRAC + 1;
  localparam int BIG_W      = SCALED_W - SIZE_SHIFT;

  localparam logic [MAG_W-1:0] EPS_W_Q = MAG_W'(105);
  localparam logic [OUT_W-1:0] SIZE_MAX_OUT = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic [ROW_W-1:0]          matrix_row_0;
    logic [ROW_W-1:0]          matrix_row_1;
    logic [ROW_W-1:0]          matrix_row_2;
    logic [ROW_W-1:0]          matrix_row_3;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] pixel_size;
    logic             saturated;
    logic             no_valid_corner;
  } out_result_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIVN_W-1:0] num;
    logic [DIVN_W-1:0] quo;
  } div_lane_t;

  function automatic logic signed [ENTRY_W-1:0] mat_entry(logic [ROW_W-1:0] row, int col);
    return row[ENTRY_W*col +: ENTRY_W];
  endfunction

  // restoring division, DIV_BITS quotient bits per call
  function automatic div_lane_t div_steps(div_lane_t a, logic [MAG_W-1:0] d);
    div_lane_t        r;
    logic [REM_W-1:0] t;
    r = a;
    for (int k = 0; k < DIV_BITS; k++) begin
      t     = {r.rem[REM_W-2:0], r.num[DIVN_W-1]};
      r.num = {r.num[DIVN_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem = t - {1'b0, d};
        r.quo = {r.quo[DIVN_W-2:0], 1'b1};
      end else begin
        r.rem = t;
        r.quo = {r.quo[DIVN_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

/* src/bbox_screen_pixel_size_core.sv */
// ----------------------------------------------------------------------------
// bbox_screen_pixel_size_core
// Projects the eight corners of a box and returns its larger screen extent.
// ----------------------------------------------------------------------------
// throughput: one corner per cycle enters the shared transform and
//   13-stage divide pipeline
// busy is high while an item's corners issue, until the eighth; a new start is taken
//   in the cycle the eighth corner issues
// reset clears all valid bits and loads screen 1920x1080; no output stall
module bbox_screen_pixel_size_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  bbsps_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  output bbsps_pkg::out_result_t               out_result,
  input  logic                                 cfg_we,
  input  logic [bbsps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bbsps_pkg::SCREEN_W-1:0]       cfg_data
);
  import bbsps_pkg::*;

  // configuration
  logic [SCREEN_W-1:0] screen_w_r, screen_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_WIDTH_RST;
      screen_h_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SCREEN_WIDTH) begin
        screen_w_r <= cfg_data;
      end
      if (cfg_index == CFG_SCREEN_HEIGHT) begin
        screen_h_r <= cfg_data;
      end
    end
  end

  // corner sequencer
  in_item_t   item_r;
  logic       active_r;
  logic [2:0] cnt_r;
  logic       accept;

  assign busy   = active_r && (cnt_r != 3'd7);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (accept) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r) begin
      if (cnt_r == 3'd7) begin
        active_r <= 1'b0;
      end
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  logic [ROW_W-1:0]          rows [4];
  logic signed [COORD_W-1:0] vc   [3];

  always_comb begin
    rows[0] = item_r.matrix_row_0;
    rows[1] = item_r.matrix_row_1;
    rows[2] = item_r.matrix_row_2;
    rows[3] = item_r.matrix_row_3;
    vc[0]   = cnt_r[0] ? item_r.box_max_x : item_r.box_min_x;
    vc[1]   = cnt_r[1] ? item_r.box_max_y : item_r.box_min_y;
    vc[2]   = cnt_r[2] ? item_r.box_max_z : item_r.box_min_z;
  end

  // stage 1: products; lanes are x, y and w (columns 0, 1, 3)
  logic                     s1_v_r, s1_first_r, s1_last_r;
  logic signed [PROD_W-1:0] prod_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (cnt_r == 3'd0);
    s1_last_r  <= (cnt_r == 3'd7);
    for (int l = 0; l < 3; l++) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[l][r] <= vc[r] * mat_entry(rows[r], (l == 2) ? 3 : l);
      end
      // homogeneous 1.0 in Q8.8
      prod_r[l][3] <= PROD_W'(mat_entry(rows[3], (l == 2) ? 3 : l)) <<< ONE_SHIFT;
    end
  end

  // stage 2: sums
  logic                  s2_v_r, s2_first_r, s2_last_r;
  logic signed [P_W-1:0] p_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    for (int l = 0; l < 3; l++) begin
      p_r[l] <= P_W'(prod_r[l][0]) + P_W'(prod_r[l][1])
              + P_W'(prod_r[l][2]) + P_W'(prod_r[l][3]);
    end
  end

  // stage 3 and divider: stage index 0 holds magnitudes, signs and w check
  logic             dv_r    [DIV_STAGES+1];
  logic             dfirst_r[DIV_STAGES+1];
  logic             dlast_r [DIV_STAGES+1];
  logic             dok_r   [DIV_STAGES+1];
  logic             dnx_r   [DIV_STAGES+1];
  logic             dny_r   [DIV_STAGES+1];
  logic [MAG_W-1:0] dd_r    [DIV_STAGES+1];
  div_lane_t        lx_r    [DIV_STAGES+1];
  div_lane_t        ly_r    [DIV_STAGES+1];

  logic [MAG_W-1:0] mag [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = MAG_W'(p_r[l][P_W-1] ? -p_r[l] : p_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        dv_r[s] <= 1'b0;
      end
    end else begin
      dv_r[0] <= s2_v_r;
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_r[s+1] <= dv_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    dfirst_r[0]   <= s2_first_r;
    dlast_r[0]    <= s2_last_r;
    dok_r[0]      <= (mag[2] >= EPS_W_Q);
    dnx_r[0]      <= p_r[0][P_W-1] ^ p_r[2][P_W-1];
    dny_r[0]      <= p_r[1][P_W-1] ^ p_r[2][P_W-1];
    dd_r[0]       <= mag[2];
    lx_r[0].rem   <= '0;
    lx_r[0].quo   <= '0;
    lx_r[0].num   <= DIVN_W'({mag[0], {NDC_FRAC{1'b0}}});
    ly_r[0].rem   <= '0;
    ly_r[0].quo   <= '0;
    ly_r[0].num   <= DIVN_W'({mag[1], {NDC_FRAC{1'b0}}});
    for (int s = 0; s < DIV_STAGES; s++) begin
      dfirst_r[s+1] <= dfirst_r[s];
      dlast_r[s+1]  <= dlast_r[s];
      dok_r[s+1]    <= dok_r[s];
      dnx_r[s+1]    <= dnx_r[s];
      dny_r[s+1]    <= dny_r[s];
      dd_r[s+1]     <= dd_r[s];
      lx_r[s+1]     <= div_steps(lx_r[s], dd_r[s]);
      ly_r[s+1]     <= div_steps(ly_r[s], dd_r[s]);
    end
  end

  // ndc stage: apply sign
  logic                    n_v_r, n_first_r, n_last_r, n_ok_r;
  logic signed [NDC_W-1:0] ndc_x_r, ndc_y_r;
  logic signed [NDC_W-1:0] qx, qy;

  assign qx = {1'b0, lx_r[DIV_STAGES].quo[Q_W-1:0]};
  assign qy = {1'b0, ly_r[DIV_STAGES].quo[Q_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else begin
      n_v_r <= dv_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    n_first_r <= dfirst_r[DIV_STAGES];
    n_last_r  <= dlast_r[DIV_STAGES];
    n_ok_r    <= dok_r[DIV_STAGES];
    ndc_x_r   <= dnx_r[DIV_STAGES] ? -qx : qx;
    ndc_y_r   <= dny_r[DIV_STAGES] ? -qy : qy;
  end

  // min/max accumulation over the corners of one item
  logic                    acc_any_r;
  logic signed [NDC_W-1:0] acc_minx_r, acc_maxx_r, acc_miny_r, acc_maxy_r;
  logic                    any_nxt;
  logic signed [NDC_W-1:0] minx_nxt, maxx_nxt, miny_nxt, maxy_nxt;

  always_comb begin
    any_nxt  = n_first_r ? 1'b0 : acc_any_r;
    minx_nxt = acc_minx_r;
    maxx_nxt = acc_maxx_r;
    miny_nxt = acc_miny_r;
    maxy_nxt = acc_maxy_r;
    if (n_ok_r) begin
      if (!any_nxt) begin
        minx_nxt = ndc_x_r;
        maxx_nxt = ndc_x_r;
        miny_nxt = ndc_y_r;
        maxy_nxt = ndc_y_r;
      end else begin
        if (ndc_x_r < acc_minx_r) minx_nxt = ndc_x_r;
        if (ndc_x_r > acc_maxx_r) maxx_nxt = ndc_x_r;
        if (ndc_y_r < acc_miny_r) miny_nxt = ndc_y_r;
        if (ndc_y_r > acc_maxy_r) maxy_nxt = ndc_y_r;
      end
      any_nxt = 1'b1;
    end
  end

  logic                    f_v_r, f_any_r;
  logic signed [NDC_W-1:0] f_minx_r, f_maxx_r, f_miny_r, f_maxy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_any_r <= 1'b0;
      f_v_r     <= 1'b0;
    end else begin
      if (n_v_r) begin
        acc_any_r <= any_nxt;
      end
      f_v_r <= n_v_r && n_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (n_v_r) begin
      acc_minx_r <= minx_nxt;
      acc_maxx_r <= maxx_nxt;
      acc_miny_r <= miny_nxt;
      acc_maxy_r <= maxy_nxt;
    end
    f_any_r  <= any_nxt;
    f_minx_r <= minx_nxt;
    f_maxx_r <= maxx_nxt;
    f_miny_r <= miny_nxt;
    f_maxy_r <= maxy_nxt;
  end

  // spans
  logic              sp_v_r, sp_any_r;
  logic [SPAN_W-1:0] span_x_r, span_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_v_r <= 1'b0;
    end else begin
      sp_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sp_any_r <= f_any_r;
    span_x_r <= SPAN_W'(SPAN_W'(f_maxx_r) - SPAN_W'(f_minx_r));
    span_y_r <= SPAN_W'(SPAN_W'(f_maxy_r) - SPAN_W'(f_miny_r));
  end

  // scale by screen size
  logic                sc_v_r, sc_any_r;
  logic [SCALED_W-1:0] sc_x_r, sc_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
    end else begin
      sc_v_r <= sp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sc_any_r <= sp_any_r;
    sc_x_r   <= SCALED_W'(span_x_r) * SCALED_W'(screen_w_r);
    sc_y_r   <= SCALED_W'(span_y_r) * SCALED_W'(screen_h_r);
  end

  // output register
  logic [SCALED_W-1:0] big_full;
  logic [BIG_W-1:0]    big;
  logic                sat;

  assign big_full = (sc_x_r > sc_y_r) ? sc_x_r : sc_y_r;
  assign big      = big_full[SCALED_W-1:SIZE_SHIFT];
  assign sat      = |big[BIG_W-1:OUT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= sc_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!sc_any_r) begin
      out_result.pixel_size      <= '0;
      out_result.saturated       <= 1'b0;
      out_result.no_valid_corner <= 1'b1;
    end else begin
      out_result.pixel_size      <= sat ? SIZE_MAX_OUT : big[OUT_W-1:0];
      out_result.saturated       <= sat;
      out_result.no_valid_corner <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (active_r && cnt_r == 3'd0))
    else $error("accepted item did not start corner issue");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.no_valid_corner) |->
      (out_result.pixel_size == '0 && !out_result.saturated))
    else $error("no valid corner but nonzero size");

  a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.saturated) |-> (out_result.pixel_size == SIZE_MAX_OUT))
    else $error("saturated result not clamped");

  a_last_corner_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && cnt_r == 3'd7 && !start) |=> !active_r)
    else $error("sequencer ran past eighth corner");
`endif

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for bbox_screen_pixel_size_core
// Drives boxes and matrices through the command port under several screen
// settings. A built-in projection model predicts each pixel size, and every
// result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbsps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [ENTRY_W-1:0] Q12_ONE = 16'h1000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_valid;
  out_result_t          out_result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
  logic [SCREEN_W-1:0]  cfg_data = '0;

  bbox_screen_pixel_size_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_result(out_result), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_item_t            box_queue[$];
  out_result_t         size_expect[$];
  logic [SCREEN_W-1:0] model_width = SCREEN_WIDTH_RST;
  logic [SCREEN_W-1:0] model_height = SCREEN_HEIGHT_RST;
  int                  mismatches = 0;
  int                  n_boxes = 0;
  int                  n_sizes = 0;
  int                  n_sat = 0;
  int                  n_none = 0;
  int                  cycles = 0;
  bit                  burst_mode = 1'b0;

  function automatic longint q12(logic [ROW_W-1:0] row, int col);
    logic signed [ENTRY_W-1:0] e;
    e = row[ENTRY_W*col +: ENTRY_W];
    return longint'(e);
  endfunction

  function automatic longint ndc_quot(longint p, longint w);
    longint np, nw, q;
    np = (p < 0) ? -p : p;
    nw = (w < 0) ? -w : w;
    q = (np <<< NDC_FRAC) / nw;
    return ((p < 0) != (w < 0)) ? -q : q;
  endfunction

  function automatic out_result_t project_size(in_item_t it, logic [SCREEN_W-1:0] sw,
                                               logic [SCREEN_W-1:0] sh);
    longint lo[3], hi[3], m[4][4], v[4], p[4];
    longint nx, ny, aw, mnx, mxx, mny, mxy;
    logic [63:0] sx, sy, big;
    bit any;
    out_result_t r;
    logic [ROW_W-1:0] rows[4];
    lo[0] = longint'(it.box_min_x); lo[1] = longint'(it.box_min_y);
    lo[2] = longint'(it.box_min_z);
    hi[0] = longint'(it.box_max_x); hi[1] = longint'(it.box_max_y);
    hi[2] = longint'(it.box_max_z);
    rows[0] = it.matrix_row_0; rows[1] = it.matrix_row_1;
    rows[2] = it.matrix_row_2; rows[3] = it.matrix_row_3;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) m[i][j] = q12(rows[i], j);
    any = 1'b0;
    mnx = 0; mxx = 0; mny = 0; mxy = 0;
    for (int c = 0; c < 8; c++) begin
      v[0] = c[0] ? hi[0] : lo[0];
      v[1] = c[1] ? hi[1] : lo[1];
      v[2] = c[2] ? hi[2] : lo[2];
      v[3] = 256;
      for (int j = 0; j < 4; j++) begin
        p[j] = 0;
        for (int i = 0; i < 4; i++) p[j] += v[i] * m[i][j];
      end
      aw = (p[3] < 0) ? -p[3] : p[3];
      if (aw >= 105) begin
        nx = ndc_quot(p[0], p[3]);
        ny = ndc_quot(p[1], p[3]);
        if (!any) begin
          mnx = nx; mxx = nx; mny = ny; mxy = ny;
          any = 1'b1;
        end else begin
          if (nx < mnx) mnx = nx;
          if (nx > mxx) mxx = nx;
          if (ny < mny) mny = ny;
          if (ny > mxy) mxy = ny;
        end
      end
    end
    r = '0;
    if (!any) begin
      r.no_valid_corner = 1'b1;
      return r;
    end
    sx = 64'(mxx - mnx) * 64'(sw);
    sy = 64'(mxy - mny) * 64'(sh);
    big = ((sx > sy) ? sx : sy) >> (NDC_FRAC + 1);
    if (big > 64'(SIZE_MAX_OUT)) begin
      r.pixel_size = SIZE_MAX_OUT;
      r.saturated = 1'b1;
    end else begin
      r.pixel_size = big[OUT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(logic [15:0] e0, logic [15:0] e1,
                                                logic [15:0] e2, logic [15:0] e3);
    return {e3, e2, e1, e0};
  endfunction

  // random entry of moderate size, near-projection matrices
  function automatic logic [15:0] soft_entry();
    int v;
    v = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 8192)) - 4096;
    return 16'(v);
  endfunction

  function automatic in_item_t random_box();
    in_item_t it;
    int kind, a, b;
    logic [15:0] wc;
    kind = $urandom_range(0, 9);
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, $urandom, $urandom};
    if (kind < 2) return it;  // raw noise, every bit free
    for (int k = 0; k < 3; k++) begin
      a = int'($urandom_range(0, 4000)) - 2000;
      b = a + int'($urandom_range(0, 1500));
      if (kind == 2) begin
        a = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 65535)) - 32768;
      end
      case (k)
        0: begin it.box_min_x = 16'(a); it.box_max_x = 16'(b); end
        1: begin it.box_min_y = 16'(a); it.box_max_y = 16'(b); end
        default: begin it.box_min_z = 16'(a); it.box_max_z = 16'(b); end
      endcase
    end
    // w column: sometimes tiny so corners drop out near the epsilon
    wc = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3)) : soft_entry();
    it.matrix_row_0 = pack_row(soft_entry(), soft_entry(), soft_entry(),
                               ($urandom_range(0, 2) == 0) ? soft_entry() : 16'h0);
    it.matrix_row_1 = pack_row(soft_entry(), soft_entry(), soft_entry(),
                               ($urandom_range(0, 2) == 0) ? soft_entry() : 16'h0);
    it.matrix_row_2 = pack_row(soft_entry(), soft_entry(), soft_entry(), wc);
    it.matrix_row_3 = pack_row(soft_entry(), soft_entry(), soft_entry(),
                               ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 1)) :
                               soft_entry());
    return it;
  endfunction

  function automatic in_item_t make_box(int x0, int y0, int z0, int x1, int y1, int z1,
                                        logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                                        logic [ROW_W-1:0] r2, logic [ROW_W-1:0] r3);
    in_item_t it;
    it.box_min_x = 16'(x0); it.box_min_y = 16'(y0); it.box_min_z = 16'(z0);
    it.box_max_x = 16'(x1); it.box_max_y = 16'(y1); it.box_max_z = 16'(z1);
    it.matrix_row_0 = r0; it.matrix_row_1 = r1; it.matrix_row_2 = r2;
    it.matrix_row_3 = r3;
    return it;
  endfunction

  task automatic enqueue_box(in_item_t it);
    box_queue = {box_queue, it};
  endtask

  // driver: start held until busy is low at an edge
  int gap_left = 0;
  always @(posedge clk) begin
    logic     next_start;
    in_item_t nxt;
    next_start = start;
    if (rst_n) begin
      if (start && !busy) begin
        size_expect = {size_expect, project_size(in_item, model_width, model_height)};
        n_boxes++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (box_queue.size() > 0) begin
          nxt = box_queue.pop_front();
          in_item <= nxt;
          next_start = 1'b1;
          if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
          gap_left = burst_mode ? 0 : int'($urandom_range(0, 6));
        end
      end
    end
    start <= next_start;
  end

  // monitor
  always @(posedge clk) begin
    out_result_t want;
    if (rst_n && out_valid) begin
      if (size_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: size=%0d sat=%0b none=%0b", out_result.pixel_size,
                   out_result.saturated, out_result.no_valid_corner);
      end else begin
        want = size_expect.pop_front();
        n_sizes++;
        if (want.saturated) n_sat++;
        if (want.no_valid_corner) n_none++;
        if (out_result !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected size=%0d sat=%0b none=%0b, got size=%0d sat=%0b none=%0b",
                     n_sizes, want.pixel_size, want.saturated, want.no_valid_corner,
                     out_result.pixel_size, out_result.saturated, out_result.no_valid_corner);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("bbox_screen_pixel_size_core: mismatch");
      $finish;
    end
  end

  task automatic write_screen(logic [CFG_IDX_W-1:0] idx, logic [SCREEN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) model_width = val;
    else if (idx == CFG_SCREEN_HEIGHT) model_height = val;
  endtask

  task automatic drain();
    while (box_queue.size() > 0 || start || size_expect.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [ROW_W-1:0] ix, iy, iz, it3;
    ix  = pack_row(Q12_ONE, 16'h0, 16'h0, 16'h0);
    iy  = pack_row(16'h0, Q12_ONE, 16'h0, 16'h0);
    iz  = pack_row(16'h0, 16'h0, Q12_ONE, 16'h0);
    it3 = pack_row(16'h0, 16'h0, 16'h0, Q12_ONE);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset screen size
    enqueue_box(make_box(-256, -256, -256, 256, 256, 256, ix, iy, iz, it3));
    enqueue_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767,
                         ix, iy, iz, it3));
    enqueue_box(make_box(0, 0, 0, 0, 0, 0, '0, '0, '0, '0));  // no valid corner
    enqueue_box(make_box(100, 200, 300, 100, 200, 300, ix, iy, iz, it3));
    enqueue_box(make_box(512, 512, 0, -512, -512, 0, ix, iy, iz, it3));  // inverted
    // w right at the epsilon edge: z*m23 gives 104 then 105
    enqueue_box(make_box(-100, -100, 1, 100, 100, 1, ix, iy,
                         pack_row(16'h0, 16'h0, 16'h0, 16'd104), '0));
    enqueue_box(make_box(-100, -100, 1, 100, 100, 1, ix, iy,
                         pack_row(16'h0, 16'h0, 16'h0, 16'd105), '0));
    enqueue_box(make_box(-100, -100, 0, 100, 100, 1, ix, iy,
                         pack_row(16'h0, 16'h0, 16'h0, 16'd105), '0));  // one side
    enqueue_box(make_box(-256, -256, 0, 256, 256, 0, ix, iy, iz,
                         pack_row(16'h0, 16'h0, 16'h0, 16'hF000)));  // negative w
    enqueue_box(make_box(-32768, -32768, 0, 32767, 32767, 0, ix, iy, iz,
                         pack_row(16'h0, 16'h0, 16'h0, 16'h0001)));  // saturates
    enqueue_box(make_box(-32768, 0, 0, 32767, 0, 0, {4{16'h7FFF}}, {4{16'h8000}},
                         {4{16'h7FFF}}, {4{16'h8000}}));
    enqueue_box(make_box(32767, -32768, 32767, -32768, 32767, -32768,
                         {4{16'h8000}}, {4{16'h7FFF}}, {4{16'h8000}},
                         {4{16'h7FFF}}));
    enqueue_box(make_box(-1, -1, -1, -1, -1, -1, {4{16'hFFFF}}, {4{16'hFFFF}},
                         {4{16'hFFFF}}, {4{16'hFFFF}}));
    enqueue_box(make_box(-2560, -2560, 256, 2560, 2560, 2560, ix, iy,
                         pack_row(16'h0, 16'h0, 16'h0, Q12_ONE), '0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_screen(CFG_SCREEN_WIDTH, 14'd1); write_screen(CFG_SCREEN_HEIGHT, 14'd1); end
        1: begin write_screen(CFG_SCREEN_WIDTH, 14'd8192);
                 write_screen(CFG_SCREEN_HEIGHT, 14'd8192); end
        2: begin write_screen(CFG_SCREEN_WIDTH, 14'h3FFF); write_screen(CFG_SCREEN_HEIGHT, 14'd0); end
        3: begin write_screen(CFG_SCREEN_WIDTH, 14'd0); write_screen(CFG_SCREEN_HEIGHT, 14'h3FFF); end
        4: begin
          // indexes past the last register must leave the screen alone
          write_screen(CFG_SCREEN_WIDTH, 14'd1920);
          write_screen(CFG_SCREEN_HEIGHT, 14'd1080);
          write_screen(2'd2, 14'd77);
          write_screen(2'd3, 14'h3FFF);
        end
        default: begin
          write_screen(CFG_SCREEN_WIDTH, 14'($urandom_range(1, 8192)));
          write_screen(CFG_SCREEN_HEIGHT, 14'($urandom_range(1, 8192)));
        end
      endcase
      for (int k = 0; k < 150; k++) enqueue_box(random_box());
      drain();
    end

    $display("ran %0d boxes over 9 screen settings: %0d saturated, %0d with no valid corner",
             n_boxes, n_sat, n_none);
    if (mismatches == 0) begin
      $display("bbox_screen_pixel_size_core: match");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("bbox_screen_pixel_size_core: mismatch");
    end
    $finish;
  end

endmodule
